// File: sv/unsigned_to_decimal_ascii_defines.svh
// Assertion macros for the converter's RTL, included by u2da_ctrl.sv.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_DEFINES_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is asserted.
`define UDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also applies during reset.
`define UDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define UDA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/u2da_pkg.sv
// Shared widths, constants and controller/datapath interface types.
`default_nettype none

package u2da_pkg;

    localparam int VALUE_W    = 16;
    localparam int CHAR_W     = 6;
    localparam int NUM_DIGITS = 5;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 4;
    localparam int LEFT_W     = 3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CNT_W-1:0]  CONV_STEPS  = 4'd15;
    localparam logic [LEFT_W-1:0] DIGITS_FULL = 3'd5;
    localparam logic [LEFT_W-1:0] DIGITS_ONE  = 3'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic align_step;
        logic emit_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;
        logic top_zero;
        logic left_one;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: sv/u2da_datapath.sv
// Shift-and-add-3 binary to BCD datapath with digit alignment and emission.
`default_nettype none

module u2da_datapath
    import u2da_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [VALUE_W-1:0] i_value,
    output t_dp_sts                 o_sts,
    output logic [CHAR_W-1:0]       o_character,
    output logic                    o_last
);

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [CNT_W-1:0]   r_cnt;
    logic [LEFT_W-1:0]  r_left;
    logic [BCD_W-1:0]   adj_bcd;

    // Any BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= i_value;
            r_bcd  <= '0;
            r_cnt  <= CONV_STEPS;
            r_left <= DIGITS_FULL;
        end else if (i_cmd.conv_step) begin
            r_bcd <= {adj_bcd[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.align_step || i_cmd.emit_step) begin
            r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
            r_left <= r_left - 1'b1;
        end
    end

    always_comb begin
        o_sts.conv_last = (r_cnt == '0);
        o_sts.top_zero  = (r_bcd[BCD_W-1 -: 4] == 4'd0);
        o_sts.left_one  = (r_left == DIGITS_ONE);
    end

    assign o_character = ASCII_ZERO + {2'b00, r_bcd[BCD_W-1 -: 4]};
    assign o_last      = (r_left == DIGITS_ONE);

endmodule

`default_nettype wire

// File: sv/u2da_ctrl.sv
// Sequencing state machine: load, convert, skip leading zeros, emit digits.
`default_nettype none

`include "unsigned_to_decimal_ascii_defines.svh"

module u2da_ctrl
    import u2da_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_ALIGN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_last) begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                // Drop leading zero digits, but always keep the units digit.
                if (i_sts.top_zero && !i_sts.left_one) begin
                    o_cmd.align_step = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stall) begin
                    if (i_sts.left_one) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);

    `UDA_ASSERT(a_cmd_onehot0, i_clk, i_rst_n, $onehot0(o_cmd), "more than one datapath command")
    `UDA_ASSERT(a_load_idle, i_clk, i_rst_n, (o_cmd.load |-> (r_state == S_IDLE && i_valid)), "load outside idle")
    `UDA_ASSERT(a_conv_to_align, i_clk, i_rst_n, ((r_state == S_CONV && i_sts.conv_last) |=> (r_state == S_ALIGN)), "conversion did not end in align")
    `UDA_ASSERT(a_emit_not_last, i_clk, i_rst_n, (o_cmd.emit_step |-> !i_sts.left_one), "shift after final digit")
    `UDA_ASSERT(a_emit_stall_hold, i_clk, i_rst_n, ((o_valid && i_stall) |-> (o_cmd == '0)), "digit moved while stalled")
    `UDA_ASSERT(a_emit_stay_valid, i_clk, i_rst_n, ((o_valid && i_stall) |=> o_valid), "emit state left while stalled")

endmodule

`default_nettype wire

// File: sv/unsigned_to_decimal_ascii.sv
// Top level: 16-bit unsigned to decimal ASCII digit stream converter.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------
//  input   | in        | i_valid / o_stall  | i_value[15:0]
//  output  | out       | o_valid / i_stall  | o_character[5:0], o_last
//
//  One item at a time: the item is accepted, converted bit by bit in the
//  shift-and-add-3 BCD datapath, then leading zero digits are suppressed
//  and the remaining digits are emitted, most significant first.
//  o_stall is high from acceptance until the final digit has been taken.
//  A stall on the output holds the current digit; reset (synchronous, active
//  low) returns the controller to idle and drops any item in progress.
`default_nettype none

module unsigned_to_decimal_ascii
    import u2da_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [CHAR_W-1:0]       o_character,
    output logic                    o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    u2da_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    u2da_datapath u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (dp_cmd),
        .i_value     (i_value),
        .o_sts       (dp_sts),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the 16-bit unsigned to decimal ASCII converter.
`timescale 1ns / 100ps

module testbench
    import u2da_pkg::*;
();

    localparam int DECIMAL_BASE  = 10;
    localparam int NUM_DIRECTED  = 20;
    localparam int NUM_RANDOM    = 460;
    localparam int CALM_TAIL     = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_digit_char;

    // A typed row carries its decimal text, one ASCII byte per digit, right-aligned.
    typedef struct packed {
        logic [VALUE_W-1:0]      value;
        logic                    typed;
        logic [8*NUM_DIGITS-1:0] text;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [VALUE_W-1:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic [CHAR_W-1:0]  o_character;
    logic               o_last;

    t_digit_char pending_chars[$];
    bit          idling_on;
    int          numbers_sent;
    int          chars_checked;
    int          five_digit_numbers;
    int          fail_count;
    int          idle_cycles;

    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{16'd0,     1'b1, "0"},
        '{16'd1,     1'b1, "1"},
        '{16'd9,     1'b1, "9"},
        '{16'd10,    1'b1, "10"},
        '{16'd10000, 1'b1, "10000"},
        '{16'd65535, 1'b1, "65535"},
        '{16'd99,    1'b0, ""},
        '{16'd100,   1'b0, ""},
        '{16'd999,   1'b0, ""},
        '{16'd1000,  1'b0, ""},
        '{16'd9999,  1'b0, ""},
        '{16'd34463, 1'b0, ""},
        '{16'd32768, 1'b0, ""},
        '{16'd12345, 1'b0, ""},
        '{16'd50000, 1'b0, ""},
        '{16'd10001, 1'b0, ""},
        '{16'd60006, 1'b0, ""},
        '{16'h5555,  1'b0, ""},
        '{16'hAAAA,  1'b0, ""},
        '{16'd7,     1'b0, ""}
    };

    unsigned_to_decimal_ascii uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Splits a number into decimal digits and queues its characters, leading zeros dropped.
    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] value);
        int          rest;
        int          first;
        int          k;
        logic [3:0]  digit [NUM_DIGITS];
        t_digit_char c;
        rest = value;
        for (k = NUM_DIGITS - 1; k >= 0; k--) begin
            digit[k] = 4'(rest % DECIMAL_BASE);
            rest     = rest / DECIMAL_BASE;
        end
        first = NUM_DIGITS - 1;
        for (k = NUM_DIGITS - 2; k >= 0; k--) begin
            if (digit[k] != 4'd0) begin
                first = k;
            end
        end
        for (k = first; k < NUM_DIGITS; k++) begin
            c.character = CHAR_W'(ASCII_ZERO + digit[k]);
            c.last      = (k == NUM_DIGITS - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic void queue_typed_text(input logic [8*NUM_DIGITS-1:0] text);
        int          k;
        t_digit_char c;
        for (k = NUM_DIGITS - 1; k >= 0; k--) begin
            if (text[8*k +: 8] != 8'd0) begin
                c.character = text[8*k +: CHAR_W];
                c.last      = (k == 0);
                pending_chars.push_back(c);
            end
        end
    endfunction

    // Mostly picks a digit count first so that short and long numbers are equally common.
    function automatic logic [VALUE_W-1:0] pick_value();
        int n;
        int lo;
        int hi;
        if ($urandom_range(0, 5) == 0) begin
            return VALUE_W'($urandom);
        end
        n  = $urandom_range(1, NUM_DIGITS);
        lo = 1;
        for (int k = 1; k < n; k++) begin
            lo = lo * DECIMAL_BASE;
        end
        hi = lo * DECIMAL_BASE - 1;
        if (n == 1) begin
            lo = 0;
        end
        if (hi > 65535) begin
            hi = 65535;
        end
        return VALUE_W'($urandom_range(hi, lo));
    endfunction

    // Entered and left at a falling edge.
    task automatic send_number(input logic [VALUE_W-1:0] value, input logic typed,
                               input logic [8*NUM_DIGITS-1:0] text);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_value = value;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        if (typed) begin
            queue_typed_text(text);
        end else begin
            queue_decimal_text(value);
        end
        numbers_sent++;
        if (value >= 16'd10000) begin
            five_digit_numbers++;
        end
        @(negedge i_clk);
    endtask

    // Receiver back-pressure in random bursts.
    initial begin
        int burst_left;
        burst_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst_left > 0) begin
                burst_left--;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(1, 10) - 1;
                i_stall    = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_digit_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("%0t: character %0d last %0b arrived with nothing expected",
                             $realtime, o_character, o_last);
                end
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.character || o_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: expected character %0d last %0b, got %0d last %0b",
                                 $realtime, want.character, want.last, o_character, o_last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles with no item moving", idle_cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_value            = '0;
        idling_on          = 1'b1;
        numbers_sent       = 0;
        chars_checked      = 0;
        five_digit_numbers = 0;
        fail_count         = 0;
        idle_cycles        = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_number(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].text);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // Quiet stretches now and then, and none at all near the end.
            if (n >= NUM_RANDOM - CALM_TAIL) begin
                idling_on = 1'b0;
            end else if (n % 50 == 0) begin
                idling_on = ($urandom_range(0, 3) != 0);
            end
            send_number(pick_value(), 1'b0, '0);
        end
        i_valid = 1'b0;

        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d numbers (%0d of five digits) into %0d checked characters",
                 numbers_sent, five_digit_numbers, chars_checked);
        $display("mismatches or unexpected characters: %0d", fail_count);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
